@@ hdl/rftd_pkg.sv @@
// Shared constants, types and register codes of the reverse/forward tap delay.
// Depends on nothing; rftd_if, the top level and rftd_chk use it.
package rftd_pkg;

    localparam int DELAY_DEPTH = 1048576;
    localparam int TRAIL_DEPTH = 524288;
    localparam int SAMPLE_BITS = 24;

    localparam int LOOP_LEN_W = 21;
    localparam int GAIN_W     = 16;
    localparam int FADE_W     = 19;
    localparam int LOOK_W     = 16;
    localparam int LOC_W      = 17;
    localparam int LAST_LOC_W = 18;
    localparam int CNT_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam int LOOP_LEN_RST = 240000;
    localparam int GAIN_RST     = 13107;
    localparam int FADE_RST     = 9600;
    localparam int LOOK_RST     = 1000;

    localparam int MIN_LEN     = 1024;
    localparam int LOOP_GUARD  = 100;
    localparam int FADE_MARGIN = 10;
    localparam int FADE_STEP   = 2;
    localparam int LOC_ONE     = 65536;
    localparam int GAIN_ONE    = 32768;
    localparam logic [LAST_LOC_W-1:0] LOC_SENTINEL = 18'h3FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOOP_LENGTH    = 3'd0,
        REG_FEEDBACK_GAIN  = 3'd1,
        REG_FADE_LENGTH    = 3'd2,
        REG_FADE_LOOKAHEAD = 3'd3
    } t_cfg_reg;

endpackage

@@ hdl/rftd_if.sv @@
// Request channels of the tap delay: sample input, tap output, register write.
// Depends on rftd_pkg.
interface rftd_in_if #(parameter int SW = rftd_pkg::SAMPLE_BITS);
    import rftd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] sample_in;
    logic [LOC_W-1:0]     forward_location;
    logic [LOC_W-1:0]     reverse_location;
    modport source(output valid, sample_in, forward_location, reverse_location, input ready);
    modport sink(input valid, sample_in, forward_location, reverse_location, output ready);
endinterface

interface rftd_out_if #(parameter int SW = rftd_pkg::SAMPLE_BITS);
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] reverse_out;
    logic signed [SW-1:0] forward_out;
    modport source(output valid, reverse_out, forward_out, input ready);
    modport sink(input valid, reverse_out, forward_out, output ready);
endinterface

interface rftd_cfg_if;
    import rftd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/rftd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rftd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/reverse_forward_tap_delay.sv @@
// Top level of the reverse/forward tap delay with trail crossfade.
// Depends on rftd_pkg, rftd_if and rftd_ram.
//
// Usage: i_in carries one request per audio sample (sample_in, forward_location,
// reverse_location); o_out returns one request (reverse_out, forward_out) for
// each. i_cfg writes loop_length, feedback_gain, fade_length, fade_lookahead
// at indices 0..3; other indices are ignored. i_cfg is always ready; write only
// while no sample is in flight.
// Each sample steps through the states in order, the fade weight and crossfade
// multiply only while a crossfade runs; the next sample is accepted once the last
// has left for the output register. The pace is set by the shared
// one-bit-per-cycle divider (35 steps for the loop modulo, 35 more for the fade
// weight) and the sequenced accesses on the single read port of each store.
// i_in.ready is low while a sample is worked on, and while the finished result
// waits for the output register while the receiver stalls; o_out holds then.
// After reset both stores are cleared, one address a cycle, while i_in.ready
// stays low. Store depths are powers of two.
module reverse_forward_tap_delay #(
    parameter int DELAY_DEPTH = rftd_pkg::DELAY_DEPTH,
    parameter int TRAIL_DEPTH = rftd_pkg::TRAIL_DEPTH,
    parameter int SAMPLE_BITS = rftd_pkg::SAMPLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rftd_in_if.sink    i_in,
    rftd_out_if.source o_out,
    rftd_cfg_if.sink   i_cfg
);
    import rftd_pkg::*;

    localparam int SW  = SAMPLE_BITS;
    localparam int IW  = $clog2(DELAY_DEPTH);
    localparam int LW  = $clog2(DELAY_DEPTH + 1);
    localparam int TW  = $clog2(TRAIL_DEPTH);
    localparam int MAW = ((LW > SW + 1) ? LW : SW + 1) + 1;
    localparam int PW  = MAW + 18;
    localparam int SEW = SW + 2;
    localparam int DW  = FADE_W + 16;
    localparam int DVW = (LW > FADE_W) ? LW : FADE_W;
    localparam int DCW = $clog2(DW + 1);
    localparam logic signed [SEW-1:0] SMAX = {3'b000, {(SW-1){1'b1}}};
    localparam logic signed [SEW-1:0] SMIN = {3'b111, {(SW-1){1'b0}}};

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_CLEAR = 17'h00002,
        S_MULF  = 17'h00004,
        S_PLF   = 17'h00008,
        S_MULR  = 17'h00010,
        S_PLR   = 17'h00020,
        S_MULFB = 17'h00040,
        S_DRY   = 17'h00080,
        S_DIVM  = 17'h00100,
        S_RDLA  = 17'h00200,
        S_WR    = 17'h00400,
        S_RDF   = 17'h00800,
        S_RDRV  = 17'h01000,
        S_GETRV = 17'h02000,
        S_DIVW  = 17'h04000,
        S_MULX  = 17'h08000,
        S_FIN   = 17'h10000
    } t_state;

    t_state                  r_state;
    logic                    r_out_pend;
    logic [LW-1:0]           r_clr;
    logic [LOOP_LEN_W-1:0]   r_cfg_len;
    logic [GAIN_W-1:0]       r_cfg_gain;
    logic [FADE_W-1:0]       r_cfg_fade;
    logic [LOOK_W-1:0]       r_cfg_la;

    logic [IW-1:0]           r_wi, r_fi, r_ri;
    logic [TW-1:0]           r_ti;
    logic                    r_fading;
    logic [CNT_W-1:0]        r_td, r_fc;
    logic signed [SW-1:0]    r_last_wet;
    logic [LAST_LOC_W-1:0]   r_last_floc, r_last_rloc;

    logic signed [SW-1:0]    r_x, r_dry, r_fwd, r_ms, r_ts, r_rev;
    logic [LOC_W-1:0]        r_floc, r_rloc;
    logic signed [PW-1:0]    r_prod;
    logic [DVW-1:0]          r_rem, r_dvs;
    logic [DW-1:0]           r_dvd;
    logic [DCW-1:0]          r_dcnt;
    logic                    r_out_valid;
    logic signed [SW-1:0]    r_out_rev, r_out_fwd;

    logic [LW-1:0]           len;
    logic [GAIN_W-1:0]       gain;
    logic [FADE_W-1:0]       fade;
    logic [LOC_W-1:0]        floc_sat, rloc_sat;
    logic signed [MAW-1:0]   mul_a;
    logic signed [17:0]      mul_b;
    logic [LW-1:0]           pl_dist, pl_idx;
    logic [IW-1:0]           pl_base;
    logic signed [PW-1:0]    fb, xf;
    logic signed [SEW-1:0]   dry_sum;
    logic [DVW:0]            rem_sh;
    logic                    div_ge;
    logic [CNT_W-1:0]        td_lim;
    logic [TW-1:0]           trail_back, trail_off;

    logic signed [SW-1:0]    n_rev;
    logic                    n_fading;
    logic [CNT_W-1:0]        n_td, n_fc;
    logic [LW-1:0]           wi_inc, fi_inc;
    logic [IW-1:0]           n_wi, n_fi, n_ri;
    logic [LW:0]             wr_dist;

    logic                    d_we;
    logic [IW-1:0]           d_waddr, d_raddr;
    logic [SW-1:0]           d_wdata, d_rdata;
    logic                    t_we;
    logic [TW-1:0]           t_waddr;
    logic [SW-1:0]           t_wdata, t_rdata;

    assign i_in.ready        = (r_state == S_IDLE) && !r_out_pend;
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.reverse_out = r_out_rev;
    assign o_out.forward_out = r_out_fwd;

    always_comb begin
        if (r_cfg_len < LOOP_LEN_W'(MIN_LEN)) begin
            len = LW'(MIN_LEN);
        end else if (32'(r_cfg_len) > 32'(DELAY_DEPTH)) begin
            len = LW'(DELAY_DEPTH);
        end else begin
            len = LW'(r_cfg_len);
        end
        gain     = (r_cfg_gain > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : r_cfg_gain;
        fade     = (r_cfg_fade == '0) ? FADE_W'(1) : r_cfg_fade;
        floc_sat = (i_in.forward_location > LOC_W'(LOC_ONE)) ? LOC_W'(LOC_ONE)
                                                             : i_in.forward_location;
        rloc_sat = (i_in.reverse_location > LOC_W'(LOC_ONE)) ? LOC_W'(LOC_ONE)
                                                             : i_in.reverse_location;
        td_lim   = CNT_W'(r_cfg_la) + CNT_W'(FADE_MARGIN);
    end

    // shared multiplier operands
    always_comb begin
        mul_a = $signed(MAW'(len - LW'(LOOP_GUARD)));
        mul_b = $signed({1'b0, r_floc});
        case (r_state)
            S_MULR:  mul_b = $signed({1'b0, r_rloc});
            S_MULFB: begin
                mul_a = MAW'(r_last_wet);
                mul_b = $signed(18'(gain));
            end
            S_MULX:  begin
                mul_a = MAW'(r_ts) - MAW'(r_ms);
                mul_b = $signed({1'b0, r_dvd[LOC_W-1:0]});
            end
            default: ;
        endcase
    end

    always_comb begin
        pl_dist = r_prod[16 +: LW];
        pl_base = r_wi;
        if (LW'(pl_base) >= pl_dist) begin
            pl_idx = LW'(pl_base) - pl_dist;
        end else begin
            pl_idx = LW'(pl_base) + len - pl_dist;
        end
        fb      = (r_prod + PW'(16384)) >>> 15;
        dry_sum = SEW'(r_x) + SEW'(fb);
        xf      = (r_prod + PW'(32768)) >>> 16;
        rem_sh  = {r_rem, r_dvd[DW-1]};
        div_ge  = rem_sh >= {1'b0, r_dvs};
        trail_back = TW'(r_td + CNT_W'(FADE_STEP));
        trail_off  = r_ti - trail_back;
    end

    // end-of-sample state update
    always_comb begin
        n_fading = r_fading;
        n_td     = r_td;
        n_fc     = r_fc;
        n_rev    = r_ms;
        if (r_fading) begin
            if (r_td > td_lim) begin
                if (r_fc > CNT_W'(fade)) begin
                    n_fading = 1'b0;
                end else begin
                    n_rev = SW'(xf + PW'(r_ms));
                end
                n_fc = r_fc + CNT_W'(FADE_STEP);
            end else begin
                n_rev = r_ts;
                n_fc  = '0;
            end
            n_td = r_td + CNT_W'(FADE_STEP);
        end else begin
            n_td = '0;
        end
        wi_inc = LW'(r_wi) + LW'(1);
        fi_inc = LW'(r_fi) + LW'(1);
        n_wi   = (wi_inc >= len) ? '0 : IW'(wi_inc);
        n_fi   = (fi_inc >= len) ? '0 : IW'(fi_inc);
        if (n_wi > r_ri) begin
            wr_dist = (LW+1)'(len) - (LW+1)'(n_wi) + (LW+1)'(r_ri);
        end else begin
            wr_dist = (LW+1)'(r_ri) - (LW+1)'(n_wi);
        end
        if (!n_fading && wr_dist < (LW+1)'(r_cfg_la)) begin
            n_fading = 1'b1;
            n_td     = '0;
        end
        if (r_ri == '0 || LW'(r_ri) > len) begin
            n_ri = IW'(len - LW'(1));
        end else begin
            n_ri = r_ri - IW'(1);
        end
    end

    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_wi;
        d_wdata = r_dry;
        t_we    = 1'b0;
        t_waddr = r_ti;
        t_wdata = d_rdata;
        case (r_state)
            S_CLEAR: begin
                d_we    = 1'b1;
                d_waddr = IW'(r_clr);
                d_wdata = '0;
                t_we    = 32'(r_clr) < TRAIL_DEPTH;
                t_waddr = TW'(r_clr);
                t_wdata = '0;
            end
            S_WR: begin
                d_we = 1'b1;
                t_we = 1'b1;
            end
            default: ;
        endcase
        case (r_state)
            S_RDLA:  d_raddr = IW'(r_rem);
            S_RDF:   d_raddr = r_fi;
            default: d_raddr = r_ri;
        endcase
    end

    rftd_ram #(.WIDTH(SW), .DEPTH(DELAY_DEPTH)) u_delay (
        .i_clk, .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    rftd_ram #(.WIDTH(SW), .DEPTH(TRAIL_DEPTH)) u_trail (
        .i_clk, .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(trail_off), .o_rdata(t_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_len   <= LOOP_LEN_W'(LOOP_LEN_RST);
            r_cfg_gain  <= GAIN_W'(GAIN_RST);
            r_cfg_fade  <= FADE_W'(FADE_RST);
            r_cfg_la    <= LOOK_W'(LOOK_RST);
            r_wi        <= '0;
            r_fi        <= '0;
            r_ri        <= '0;
            r_ti        <= '0;
            r_fading    <= 1'b0;
            r_td        <= '0;
            r_fc        <= '0;
            r_last_wet  <= '0;
            r_last_floc <= LOC_SENTINEL;
            r_last_rloc <= LOC_SENTINEL;
            r_dcnt      <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_LOOP_LENGTH:    r_cfg_len  <= LOOP_LEN_W'(i_cfg.data);
                    REG_FEEDBACK_GAIN:  r_cfg_gain <= GAIN_W'(i_cfg.data);
                    REG_FADE_LENGTH:    r_cfg_fade <= FADE_W'(i_cfg.data);
                    REG_FADE_LOOKAHEAD: r_cfg_la   <= LOOK_W'(i_cfg.data);
                    default: ;
                endcase
            end
            // drain the output register
            if (r_out_pend && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
                r_out_rev   <= r_rev;
                r_out_fwd   <= r_fwd;
                r_out_pend  <= 1'b0;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_MULF || r_state == S_MULR || r_state == S_MULFB
                    || r_state == S_MULX) begin
                r_prod <= mul_a * mul_b;
            end
            if (r_state == S_DIVM || r_state == S_DIVW) begin
                r_rem  <= div_ge ? DVW'(rem_sh - {1'b0, r_dvs}) : DVW'(rem_sh);
                r_dvd  <= {r_dvd[DW-2:0], div_ge};
                r_dcnt <= r_dcnt - DCW'(1);
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + LW'(1);
                    if (32'(r_clr) == DELAY_DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid && !r_out_pend) begin
                        r_x     <= i_in.sample_in;
                        r_floc  <= floc_sat;
                        r_rloc  <= rloc_sat;
                        r_state <= S_MULF;
                    end
                end
                S_MULF: r_state <= S_PLF;
                S_PLF: begin
                    if (LAST_LOC_W'(r_floc) != r_last_floc) begin
                        r_last_floc <= LAST_LOC_W'(r_floc);
                        r_fi        <= IW'(pl_idx);
                    end
                    r_state <= S_MULR;
                end
                S_MULR: r_state <= S_PLR;
                S_PLR: begin
                    if (LAST_LOC_W'(r_rloc) != r_last_rloc) begin
                        r_last_rloc <= LAST_LOC_W'(r_rloc);
                        r_ri        <= IW'(pl_idx);
                    end
                    r_state <= S_MULFB;
                end
                S_MULFB: r_state <= S_DRY;
                S_DRY: begin
                    if (dry_sum > SMAX) begin
                        r_dry <= SW'(SMAX);
                    end else if (dry_sum < SMIN) begin
                        r_dry <= SW'(SMIN);
                    end else begin
                        r_dry <= SW'(dry_sum);
                    end
                    // lookahead address modulo loop length
                    r_dvd   <= DW'(LW'(r_wi) + LW'(r_cfg_la) + (LW+1)'(0));
                    r_rem   <= '0;
                    r_dvs   <= DVW'(len);
                    r_dcnt  <= DCW'(DW);
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= S_RDLA;
                    end
                end
                S_RDLA: r_state <= S_WR;
                S_WR: r_state <= S_RDF;
                S_RDF: r_state <= S_RDRV;
                S_RDRV: begin
                    r_fwd   <= d_rdata;
                    r_state <= S_GETRV;
                end
                S_GETRV: begin
                    r_ms    <= d_rdata;
                    r_ts    <= t_rdata;
                    if (r_fading && r_td > td_lim && r_fc <= CNT_W'(fade)) begin
                        r_dvd   <= DW'({FADE_W'(fade - FADE_W'(r_fc)), 16'b0});
                        r_rem   <= '0;
                        r_dvs   <= DVW'(fade);
                        r_dcnt  <= DCW'(DW);
                        r_state <= S_DIVW;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIVW: begin
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= S_MULX;
                    end
                end
                S_MULX: r_state <= S_FIN;
                S_FIN: begin
                    r_rev      <= n_rev;
                    r_last_wet <= n_rev;
                    r_fading   <= n_fading;
                    r_td       <= n_td;
                    r_fc       <= n_fc;
                    r_wi       <= n_wi;
                    r_fi       <= n_fi;
                    r_ri       <= n_ri;
                    r_ti       <= (32'(r_ti) + 1 >= TRAIL_DEPTH) ? '0 : r_ti + TW'(1);
                    r_out_pend <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/rftd_chk.sv @@
// Port-level checks of the tap delay, bound to the top level.
// Depends on rftd_pkg, and on rftd_if through the bound top level ports.
module rftd_chk #(
    parameter int SW = rftd_pkg::SAMPLE_BITS
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [SW-1:0] i_out_rev,
    input logic [SW-1:0] i_out_fwd
);
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accept");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during store clear");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_rev)
            && $stable(i_out_fwd))
        else $error("stalled output request changed");
endmodule

bind reverse_forward_tap_delay rftd_chk #(.SW(SAMPLE_BITS)) u_rftd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_rev   (o_out.reverse_out),
    .i_out_fwd   (o_out.forward_out)
);
